// ----- hw/rtl/pted_pkg.sv -----
package pted_pkg;

  localparam int FIELD_COUNT  = 5;
  localparam int BYTE_W       = 8;
  localparam int FEAT_W       = 17;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 9;
  localparam int PHASE_W      = 3;

  // Result buffer geometry
  localparam int RESULT_DEPTH = 4;
  localparam int RPTR_W       = 2;
  localparam int RCNT_W       = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 2'd1;

  // Decoder phase: waiting for a lead byte, or 1 + index of the next field
  localparam logic [PHASE_W-1:0] PHASE_LEAD = 3'd0;
  localparam logic [PHASE_W-1:0] NO_FIELD   = 3'd5;

  // Field slots
  localparam int FLD_NOTE   = 0;
  localparam int FLD_EFFECT = 3;
  localparam int FLD_PARAM  = 4;

  localparam logic [4:0] UNPACKED_MASK = 5'b11110;

  // Effect numbers
  localparam logic [7:0] EFF_EXT_E   = 8'd14;
  localparam logic [7:0] EFF_UNUSED_I = 8'd18;
  localparam logic [7:0] EFF_UNUSED_J = 8'd19;
  localparam logic [7:0] EFF_ENV_POS = 8'd21;
  localparam logic [7:0] EFF_UNUSED_M = 8'd22;
  localparam logic [7:0] EFF_UNUSED_N = 8'd23;
  localparam logic [7:0] EFF_UNUSED_O = 8'd24;
  localparam logic [7:0] EFF_UNUSED_Q = 8'd26;
  localparam logic [7:0] EFF_UNUSED_S = 8'd28;
  localparam logic [7:0] EFF_UNUSED_U = 8'd30;
  localparam logic [7:0] EFF_UNUSED_V = 8'd31;
  localparam logic [7:0] EFF_UNUSED_W = 8'd32;
  localparam logic [7:0] EFF_EXT_X   = 8'd33;
  localparam logic [7:0] EFF_EXT_Y   = 8'd34;
  localparam logic [7:0] EFF_FILT_A  = 8'd35;
  localparam logic [7:0] EFF_FILT_B  = 8'd36;
  localparam logic [7:0] EFF_FIRST_UNKNOWN = 8'd37;

  // Feature bit positions
  localparam int FT_ENV_POS   = 0;
  localparam int FT_EXTENSION = 1;
  localparam int FT_FILTER    = 2;
  localparam int FT_UNUSED_I  = 3;
  localparam int FT_UNKNOWN_X = 14;
  localparam int FT_REVERSE   = 15;
  localparam int FT_UNKNOWN   = 16;

  typedef logic [FIELD_COUNT-1:0][BYTE_W-1:0] fields_t;
  typedef logic [FEAT_W-1:0] feat_t;

  typedef struct packed {
    fields_t fields;
    logic    status;
    feat_t   features;
    logic    done;
  } result_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  // Fields that follow a lead byte
  function automatic logic [4:0] needed_mask(input logic [7:0] lead);
    needed_mask = lead[7] ? lead[4:0] : UNPACKED_MASK;
  endfunction

  // First flagged field at or above a slot, NO_FIELD when none is left
  function automatic logic [PHASE_W-1:0] next_field(input logic [4:0] mask,
                                                    input logic [PHASE_W-1:0] from);
    logic [PHASE_W-1:0] r;
    r = NO_FIELD;
    for (int i = FIELD_COUNT - 1; i >= 0; i--) begin
      if (mask[i] && (PHASE_W'(i) >= from)) r = PHASE_W'(i);
    end
    return r;
  endfunction

  // Feature flags raised by one effect/parameter pair
  function automatic feat_t effect_features(input logic [7:0] effect,
                                            input logic [7:0] param);
    feat_t f;
    logic [3:0] hi;
    f  = '0;
    hi = param[7:4];
    case (effect)
      EFF_ENV_POS:            f[FT_ENV_POS] = 1'b1;
      EFF_EXT_Y:              f[FT_EXTENSION] = 1'b1;
      EFF_FILT_A, EFF_FILT_B: begin
        f[FT_EXTENSION] = 1'b1;
        f[FT_FILTER]    = 1'b1;
      end
      EFF_UNUSED_I: f[FT_UNUSED_I + 0] = 1'b1;
      EFF_UNUSED_J: f[FT_UNUSED_I + 1] = 1'b1;
      EFF_UNUSED_M: f[FT_UNUSED_I + 2] = 1'b1;
      EFF_UNUSED_N: f[FT_UNUSED_I + 3] = 1'b1;
      EFF_UNUSED_O: f[FT_UNUSED_I + 4] = 1'b1;
      EFF_UNUSED_Q: f[FT_UNUSED_I + 5] = 1'b1;
      EFF_UNUSED_S: f[FT_UNUSED_I + 6] = 1'b1;
      EFF_UNUSED_U: f[FT_UNUSED_I + 7] = 1'b1;
      EFF_UNUSED_V: f[FT_UNUSED_I + 8] = 1'b1;
      EFF_UNUSED_W: f[FT_UNUSED_I + 9] = 1'b1;
      EFF_EXT_E: begin
        if (hi == 4'hf) begin
          f[FT_EXTENSION] = 1'b1;
          f[FT_FILTER]    = 1'b1;
        end
      end
      EFF_EXT_X: begin
        case (hi) inside
          4'h0, 4'h1, 4'h2:  f = '0;
          4'h5, 4'h6, 4'ha:  f[FT_EXTENSION] = 1'b1;
          4'h9: begin
            f[FT_EXTENSION] = 1'b1;
            f[FT_REVERSE]   = (param[3:0] >= 4'he);
          end
          default:           f[FT_UNKNOWN_X] = 1'b1;
        endcase
      end
      default: begin
        if (effect >= EFF_FIRST_UNKNOWN) f[FT_UNKNOWN] = 1'b1;
      end
    endcase
    return f;
  endfunction

endpackage

// ----- hw/rtl/pted_if.sv -----
interface pted_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_is_last;

  modport source (output valid, output data_byte, output byte_is_last, input ready);
  modport sink   (input valid, input data_byte, input byte_is_last, output ready);
endinterface

interface pted_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  note_value;
  logic [7:0]  instrument_value;
  logic [7:0]  volume_value;
  logic [7:0]  effect_value;
  logic [7:0]  param_value;
  logic        status;
  logic [16:0] feature_bits;
  logic        pattern_done;

  modport source (output valid, output note_value, output instrument_value,
                  output volume_value, output effect_value, output param_value,
                  output status, output feature_bits, output pattern_done,
                  input ready);
  modport sink   (input valid, input note_value, input instrument_value,
                  input volume_value, input effect_value, input param_value,
                  input status, input feature_bits, input pattern_done,
                  output ready);
endinterface

interface pted_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [8:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- hw/rtl/pted_out_fifo.sv -----
module pted_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  pted_pkg::push_t    push,
  input  pted_pkg::result_t  item0,
  input  pted_pkg::result_t  item1,
  output logic               room,
  output logic               out_valid,
  output pted_pkg::result_t  out_item,
  input  logic               out_ready
);

  pted_pkg::result_t                     mem_r [pted_pkg::RESULT_DEPTH];
  logic [pted_pkg::RPTR_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [pted_pkg::RPTR_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [pted_pkg::RCNT_W-1:0]           count_r, count_nxt;
  logic [pted_pkg::RPTR_W-1:0]           wr_ptr_p1;
  logic                                  pop;
  logic [pted_pkg::RCNT_W-1:0]           push_n;

  // Accept only while two slots are free
  assign room      = (count_r <= pted_pkg::RCNT_W'(pted_pkg::RESULT_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + pted_pkg::RPTR_W'(1);

  always_comb begin
    push_n     = pted_pkg::RCNT_W'(push.first) + pted_pkg::RCNT_W'(push.second);
    wr_ptr_nxt = wr_ptr_r + push_n[pted_pkg::RPTR_W-1:0];
    rd_ptr_nxt = rd_ptr_r + pted_pkg::RPTR_W'(pop);
    count_nxt  = count_r + push_n - pted_pkg::RCNT_W'(pop);
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store results, a second one right after the first
  always_ff @(posedge clk) begin
    if (push.first)  mem_r[wr_ptr_r]  <= item0;
    if (push.second) mem_r[wr_ptr_p1] <= item1;
  end

endmodule

// ----- hw/rtl/tracker_pattern_event_decoder.sv -----
// A byte that completes an event writes its result into the result buffer, which shows it
// on out_ch; a byte that ends the data early adds a second result behind it.
// Throughput: one byte per cycle; in_ch.ready drops only when the four-entry
// result buffer has fewer than two free slots.
// Reset (synchronous, rst_n low): decoder rearmed, features cleared, buffer
// emptied, channel_count 0 and row_count 64 (MAX_ROWS if smaller).
module tracker_pattern_event_decoder #(
  parameter int CHAN_LIMIT = 256,
  parameter int MAX_ROWS   = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  pted_in_if.sink    in_ch,
  pted_out_if.source out_ch,
  pted_cfg_if.sink   cfg_ch
);

  localparam int CH_W  = $clog2(CHAN_LIMIT + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int CNT_W = CH_W + ROW_W;
  localparam int ROW_RESET_VAL = (64 > MAX_ROWS) ? MAX_ROWS : 64;

  // Configuration, held clamped, with the event total kept alongside
  logic [CH_W-1:0]  chan_r;
  logic [ROW_W-1:0] row_r;
  logic [CNT_W-1:0] total_r;
  logic [CH_W-1:0]  wr_chan;
  logic [ROW_W-1:0] wr_row;
  logic             cfg_fire;

  // Decoder state
  logic [pted_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [7:0]                   lead_r, lead_nxt;
  pted_pkg::fields_t            part_r, part_nxt;
  logic [CNT_W-1:0]             done_cnt_r, done_cnt_nxt;
  logic                         finished_r, finished_nxt;
  pted_pkg::feat_t              sticky_r, sticky_nxt;

  // Per-byte working values
  logic                         in_fire;
  logic                         in_last;
  logic [7:0]                   lead_v;
  pted_pkg::fields_t            flds;
  pted_pkg::fields_t            trunc;
  logic [pted_pkg::PHASE_W-1:0] slot;
  logic [pted_pkg::PHASE_W-1:0] from;
  logic [pted_pkg::PHASE_W-1:0] nf;
  pted_pkg::feat_t              feat;
  logic [CNT_W-1:0]             cnt_inc;

  pted_pkg::push_t   push;
  pted_pkg::result_t res0, res1;
  pted_pkg::result_t out_item;
  logic              room;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    wr_chan = (int'(cfg_ch.wr_data) > CHAN_LIMIT) ? CH_W'(CHAN_LIMIT)
                                                  : CH_W'(cfg_ch.wr_data);
    wr_row  = (int'(cfg_ch.wr_data) > MAX_ROWS) ? ROW_W'(MAX_ROWS)
                                                : ROW_W'(cfg_ch.wr_data);
  end

  // Write registers and refresh the total in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r  <= '0;
      row_r   <= ROW_W'(ROW_RESET_VAL);
      total_r <= '0;
    end else if (cfg_fire) begin
      if (cfg_ch.reg_index == pted_pkg::CFG_CHANNEL_COUNT) begin
        chan_r  <= wr_chan;
        total_r <= CNT_W'(wr_chan) * CNT_W'(row_r);
      end else if (cfg_ch.reg_index == pted_pkg::CFG_ROW_COUNT) begin
        row_r   <= wr_row;
        total_r <= CNT_W'(chan_r) * CNT_W'(wr_row);
      end
    end
  end

  assign in_ch.ready = room;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_last     = in_ch.byte_is_last;

  // Place the byte into the event under assembly
  always_comb begin
    if (phase_r == pted_pkg::PHASE_LEAD) begin
      slot   = '0;
      lead_v = in_ch.data_byte;
      flds   = '0;
      if (!in_ch.data_byte[7]) flds[pted_pkg::FLD_NOTE] = in_ch.data_byte;
      from   = '0;
    end else begin
      slot       = phase_r - pted_pkg::PHASE_W'(1);
      lead_v     = lead_r;
      flds       = part_r;
      flds[slot] = in_ch.data_byte;
      from       = phase_r;
    end
    nf      = pted_pkg::next_field(pted_pkg::needed_mask(lead_v), from);
    feat    = sticky_r | pted_pkg::effect_features(flds[pted_pkg::FLD_EFFECT],
                                                   flds[pted_pkg::FLD_PARAM]);
    cnt_inc = done_cnt_r + CNT_W'(1);
    trunc   = flds;
    if (!lead_v[7]) trunc[pted_pkg::FIELD_COUNT-1:1] = '0;
  end

  // Next state and results
  always_comb begin
    phase_nxt    = phase_r;
    lead_nxt     = lead_r;
    part_nxt     = part_r;
    done_cnt_nxt = done_cnt_r;
    finished_nxt = finished_r;
    sticky_nxt   = sticky_r;
    push         = '0;
    res0         = '0;
    res1         = '0;

    if (in_fire) begin
      if (finished_r || (done_cnt_r >= total_r)) begin
        // Drop extra bytes; rearm on the marked last one
        if (in_last) begin
          phase_nxt    = pted_pkg::PHASE_LEAD;
          lead_nxt     = '0;
          part_nxt     = '0;
          done_cnt_nxt = '0;
          finished_nxt = 1'b0;
        end
      end else if (nf != pted_pkg::NO_FIELD) begin
        if (!in_last) begin
          phase_nxt = nf + pted_pkg::PHASE_W'(1);
          lead_nxt  = lead_v;
          part_nxt  = flds;
        end else begin
          // Event cut short by the end of the data
          push.first    = 1'b1;
          res0.fields   = trunc;
          res0.status   = 1'b1;
          res0.features = sticky_r;
          res0.done     = 1'b1;
          phase_nxt     = pted_pkg::PHASE_LEAD;
          lead_nxt      = '0;
          part_nxt      = '0;
          done_cnt_nxt  = '0;
          finished_nxt  = 1'b0;
        end
      end else begin
        // Event complete
        sticky_nxt    = feat;
        phase_nxt     = pted_pkg::PHASE_LEAD;
        lead_nxt      = lead_v;
        part_nxt      = flds;
        push.first    = 1'b1;
        res0.fields   = flds;
        res0.status   = 1'b0;
        res0.features = feat;
        res0.done     = 1'b0;
        if (cnt_inc >= total_r) begin
          res0.done = 1'b1;
          if (in_last) begin
            lead_nxt     = '0;
            part_nxt     = '0;
            done_cnt_nxt = '0;
            finished_nxt = 1'b0;
          end else begin
            done_cnt_nxt = cnt_inc;
            finished_nxt = 1'b1;
          end
        end else if (in_last) begin
          // Data ended with events still due
          push.second   = 1'b1;
          res1.fields   = '0;
          res1.status   = 1'b1;
          res1.features = feat;
          res1.done     = 1'b1;
          lead_nxt      = '0;
          part_nxt      = '0;
          done_cnt_nxt  = '0;
          finished_nxt  = 1'b0;
        end else begin
          done_cnt_nxt = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= pted_pkg::PHASE_LEAD;
      lead_r     <= '0;
      part_r     <= '0;
      done_cnt_r <= '0;
      finished_r <= 1'b0;
      sticky_r   <= '0;
    end else begin
      phase_r    <= phase_nxt;
      lead_r     <= lead_nxt;
      part_r     <= part_nxt;
      done_cnt_r <= done_cnt_nxt;
      finished_r <= finished_nxt;
      sticky_r   <= sticky_nxt;
    end
  end

  pted_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .item0     (res0),
    .item1     (res1),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_item  (out_item),
    .out_ready (out_ch.ready)
  );

  assign out_ch.note_value       = out_item.fields[0];
  assign out_ch.instrument_value = out_item.fields[1];
  assign out_ch.volume_value     = out_item.fields[2];
  assign out_ch.effect_value     = out_item.fields[3];
  assign out_ch.param_value      = out_item.fields[4];
  assign out_ch.status           = out_item.status;
  assign out_ch.feature_bits     = out_item.features;
  assign out_ch.pattern_done     = out_item.done;

endmodule

// ----- hw/rtl/pted_checker.sv -----
module pted_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_status,
  input logic        out_done,
  input logic [16:0] out_features
);

  // Buffer empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // Any error result closes the pattern
  a_error_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> out_done)
    else $error("error result without pattern end");

  // Feature flags only accumulate from one result to the next
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) ##1 out_valid |->
      ((out_features & $past(out_features)) == $past(out_features)))
    else $error("feature flag cleared between results");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_features) && $stable(out_status) && $stable(out_done)))
    else $error("stalled result changed");

endmodule

bind tracker_pattern_event_decoder pted_checker u_pted_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.status),
  .out_done     (out_ch.pattern_done),
  .out_features (out_ch.feature_bits)
);

// ----- dv/tracker_pattern_event_decoder_tb.sv -----
module tracker_pattern_event_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH_LIMIT       = 256;
  localparam int ROW_LIMIT      = 256;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BYTE_BUDGET    = 1100;

  // Indexes with no register behind them
  localparam logic [pted_pkg::CFG_IDX_W-1:0] CFG_SPARE    = 2'd2;
  localparam logic [pted_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum int {END_EXACT, END_OVERRUN, END_EARLY, END_TRUNCATED, END_NOISE} pattern_end_t;

  logic clk;
  logic rst_n;

  pted_in_if  in_ch();
  pted_out_if out_ch();
  pted_cfg_if cfg_ch();

  tracker_pattern_event_decoder #(
    .CHAN_LIMIT(CH_LIMIT),
    .MAX_ROWS  (ROW_LIMIT)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Decoder shadow state
  int unsigned         dec_phase;   // 0: lead byte next, else 1 + slot of the next field
  logic [7:0]          dec_lead;
  pted_pkg::fields_t   dec_fields;
  int unsigned         dec_events;
  bit                  dec_finished;
  pted_pkg::feat_t     dec_feat;
  logic [8:0]          shadow_channels;
  logic [8:0]          shadow_rows;

  pted_pkg::result_t   due_events[$];
  logic [7:0]          event_bytes[$];
  logic [8:0]          byte_plan[$];   // {byte_is_last, data_byte}

  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned idle_cycles;
  bit          feed_gaps;
  bit          sink_stalls;

  always #1 clk = ~clk;

  // Events in one pattern, counts clamped to the block limits
  function automatic int unsigned pattern_events();
    int unsigned c;
    int unsigned r;
    c = (shadow_channels > CH_LIMIT) ? CH_LIMIT : shadow_channels;
    r = (shadow_rows > ROW_LIMIT) ? ROW_LIMIT : shadow_rows;
    return c * r;
  endfunction

  function automatic void restart_pattern();
    dec_phase    = 0;
    dec_lead     = '0;
    dec_fields   = '0;
    dec_events   = 0;
    dec_finished = 1'b0;
  endfunction

  function automatic void push_result(pted_pkg::fields_t f, logic st, logic done);
    pted_pkg::result_t r;
    r.fields   = f;
    r.status   = st;
    r.features = dec_feat;
    r.done     = done;
    due_events.push_back(r);
  endfunction

  // Sticky flags raised by one effect column
  function automatic pted_pkg::feat_t features_of(logic [7:0] eff, logic [7:0] prm);
    pted_pkg::feat_t f;
    f = '0;
    case (eff)
      pted_pkg::EFF_ENV_POS:  f[pted_pkg::FT_ENV_POS] = 1'b1;
      pted_pkg::EFF_EXT_Y:    f[pted_pkg::FT_EXTENSION] = 1'b1;
      pted_pkg::EFF_FILT_A, pted_pkg::EFF_FILT_B: begin
        f[pted_pkg::FT_EXTENSION] = 1'b1;
        f[pted_pkg::FT_FILTER]    = 1'b1;
      end
      pted_pkg::EFF_UNUSED_I: f[pted_pkg::FT_UNUSED_I] = 1'b1;
      pted_pkg::EFF_UNUSED_J: f[pted_pkg::FT_UNUSED_I + 1] = 1'b1;
      pted_pkg::EFF_UNUSED_M: f[pted_pkg::FT_UNUSED_I + 2] = 1'b1;
      pted_pkg::EFF_UNUSED_N: f[pted_pkg::FT_UNUSED_I + 3] = 1'b1;
      pted_pkg::EFF_UNUSED_O: f[pted_pkg::FT_UNUSED_I + 4] = 1'b1;
      pted_pkg::EFF_UNUSED_Q: f[pted_pkg::FT_UNUSED_I + 5] = 1'b1;
      pted_pkg::EFF_UNUSED_S: f[pted_pkg::FT_UNUSED_I + 6] = 1'b1;
      pted_pkg::EFF_UNUSED_U: f[pted_pkg::FT_UNUSED_I + 7] = 1'b1;
      pted_pkg::EFF_UNUSED_V: f[pted_pkg::FT_UNUSED_I + 8] = 1'b1;
      pted_pkg::EFF_UNUSED_W: f[pted_pkg::FT_UNUSED_I + 9] = 1'b1;
      pted_pkg::EFF_EXT_E: begin
        if (prm[7:4] == 4'hf) begin
          f[pted_pkg::FT_EXTENSION] = 1'b1;
          f[pted_pkg::FT_FILTER]    = 1'b1;
        end
      end
      pted_pkg::EFF_EXT_X: begin
        case (prm[7:4])
          4'h0, 4'h1, 4'h2: f = '0;
          4'h5, 4'h6, 4'ha: f[pted_pkg::FT_EXTENSION] = 1'b1;
          4'h9: begin
            f[pted_pkg::FT_EXTENSION] = 1'b1;
            f[pted_pkg::FT_REVERSE]   = (prm[3:0] >= 4'he);
          end
          default: f[pted_pkg::FT_UNKNOWN_X] = 1'b1;
        endcase
      end
      default: begin
        if (eff >= pted_pkg::EFF_FIRST_UNKNOWN) f[pted_pkg::FT_UNKNOWN] = 1'b1;
      end
    endcase
    return f;
  endfunction

  // Advance the shadow decoder by one accepted byte and queue its results
  function automatic void decode_byte(logic [7:0] b, bit is_last);
    logic [4:0] present;
    int         from;
    int         nxt;
    if (dec_finished || dec_events >= pattern_events()) begin
      if (is_last) restart_pattern();
      return;
    end
    if (dec_phase == 0) begin
      dec_lead   = b;
      dec_fields = '0;
      if (!b[7]) dec_fields[pted_pkg::FLD_NOTE] = b;
      from = 0;
    end else begin
      dec_fields[dec_phase - 1] = b;
      from = dec_phase;
    end
    present = dec_lead[7] ? dec_lead[4:0] : pted_pkg::UNPACKED_MASK;
    nxt = pted_pkg::FIELD_COUNT;
    for (int i = pted_pkg::FIELD_COUNT - 1; i >= 0; i--) begin
      if (present[i] && i >= from) nxt = i;
    end
    // event still open
    if (nxt < pted_pkg::FIELD_COUNT) begin
      dec_phase = nxt + 1;
      if (is_last) begin
        if (!dec_lead[7]) dec_fields[4:1] = '0;
        push_result(dec_fields, 1'b1, 1'b1);
        restart_pattern();
      end
      return;
    end
    // event complete
    dec_phase = 0;
    dec_feat  = dec_feat | features_of(dec_fields[pted_pkg::FLD_EFFECT],
                                       dec_fields[pted_pkg::FLD_PARAM]);
    dec_events++;
    if (dec_events >= pattern_events()) begin
      push_result(dec_fields, 1'b0, 1'b1);
      if (is_last) restart_pattern();
      else dec_finished = 1'b1;
    end else if (is_last) begin
      push_result(dec_fields, 1'b0, 1'b0);
      push_result('0, 1'b1, 1'b1);
      restart_pattern();
    end else begin
      push_result(dec_fields, 1'b0, 1'b0);
    end
  endfunction

  function automatic void compare_field(string label, logic [16:0] want, logic [16:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s: expected 0x%0h, actual 0x%0h", $time, label, want, got);
    end
  endfunction

  // Check each result transfer against the oldest expected event
  always @(posedge clk) begin
    pted_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_events.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, actual note 0x%0h status %0b done %0b",
                 $time, out_ch.note_value, out_ch.status, out_ch.pattern_done);
      end else begin
        want = due_events.pop_front();
        compare_field("note_value", 17'(want.fields[0]), 17'(out_ch.note_value));
        compare_field("instrument_value", 17'(want.fields[1]),
                      17'(out_ch.instrument_value));
        compare_field("volume_value", 17'(want.fields[2]), 17'(out_ch.volume_value));
        compare_field("effect_value", 17'(want.fields[3]), 17'(out_ch.effect_value));
        compare_field("param_value", 17'(want.fields[4]), 17'(out_ch.param_value));
        compare_field("status", 17'(want.status), 17'(out_ch.status));
        compare_field("feature_bits", want.features, out_ch.feature_bits);
        compare_field("pattern_done", 17'(want.done), 17'(out_ch.pattern_done));
      end
    end
  end

  // End the run when no channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL tracker_pattern_event_decoder");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each transfer
  initial begin : sink_side
    int unsigned hold;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      hold = sink_stalls ? $urandom_range(0, 16) : 0;
      repeat (hold) begin
        out_ch.ready = 1'b0;
        @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // Send one byte after a random gap; valid stays high for a back-to-back byte
  task automatic send_byte(logic [7:0] b, bit is_last);
    int unsigned gap;
    gap = feed_gaps ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.data_byte    = b;
    in_ch.byte_is_last = is_last;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, is_last);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Hold the input until every expected result has been taken
  task automatic settle_block();
    in_ch.valid = 1'b0;
    while (due_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [pted_pkg::CFG_IDX_W-1:0] idx,
                           logic [pted_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid     = 1'b1;
    cfg_ch.reg_index = idx;
    cfg_ch.wr_data   = val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == pted_pkg::CFG_CHANNEL_COUNT) shadow_channels = val;
    else if (idx == pted_pkg::CFG_ROW_COUNT) shadow_rows = val;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic reconfigure(int unsigned chans, int unsigned rows);
    settle_block();
    write_reg(pted_pkg::CFG_CHANNEL_COUNT, pted_pkg::CFG_DATA_W'(chans));
    write_reg(pted_pkg::CFG_ROW_COUNT, pted_pkg::CFG_DATA_W'(rows));
  endtask

  function automatic logic [7:0] field_byte(int slot);
    if (slot == pted_pkg::FLD_EFFECT) begin
      case ($urandom_range(0, 4))
        0:       return pted_pkg::EFF_EXT_X;
        1:       return pted_pkg::EFF_EXT_E;
        2, 3:    return 8'($urandom_range(0, 40));
        default: return 8'($urandom);
      endcase
    end
    return 8'($urandom);
  endfunction

  // Build one well-formed event; terse events are mostly a bare packed lead
  function automatic void make_event(bit terse);
    logic [7:0] lead;
    logic [4:0] present;
    event_bytes.delete();
    if (terse && $urandom_range(0, 7) != 0) lead = {1'b1, 2'($urandom_range(0, 3)), 5'b0};
    else if ($urandom_range(0, 2) == 0) lead = 8'($urandom_range(0, 127));
    else lead = {1'b1, 7'($urandom)};
    event_bytes.push_back(lead);
    present = lead[7] ? lead[4:0] : pted_pkg::UNPACKED_MASK;
    for (int i = 0; i < pted_pkg::FIELD_COUNT; i++) begin
      if (present[i]) event_bytes.push_back(field_byte(i));
    end
  endfunction

  function automatic void plan_events(int unsigned count, bit terse);
    for (int unsigned k = 0; k < count; k++) begin
      make_event(terse);
      foreach (event_bytes[j]) byte_plan.push_back({1'b0, event_bytes[j]});
    end
  endfunction

  // Send one pattern under the current counts, ending as the kind says
  task automatic play_pattern(pattern_end_t kind);
    int unsigned total;
    int unsigned count;
    int unsigned cut;
    bit          terse;
    total = pattern_events();
    terse = total > 16;
    byte_plan.delete();
    case (kind)
      END_EXACT, END_OVERRUN: begin
        plan_events(total, terse);
        if (kind == END_OVERRUN) begin
          repeat ($urandom_range(1, 4)) byte_plan.push_back({1'b0, 8'($urandom)});
        end
      end
      END_EARLY: begin
        count = (total > 1) ? $urandom_range(1, (total - 1 > 20) ? 20 : total - 1) : total;
        plan_events(count, terse);
      end
      END_TRUNCATED: begin
        count = (total > 0) ? $urandom_range(0, (total - 1 > 8) ? 8 : total - 1) : 0;
        plan_events(count, terse);
        do make_event(1'b0); while (event_bytes.size() < 2);
        cut = $urandom_range(0, event_bytes.size() - 2);
        for (int unsigned j = 0; j <= cut; j++) byte_plan.push_back({1'b0, event_bytes[j]});
      end
      default: begin
        repeat ($urandom_range(1, 12)) begin
          byte_plan.push_back({1'($urandom_range(0, 5) == 0), 8'($urandom)});
        end
      end
    endcase
    if (byte_plan.size() == 0) byte_plan.push_back({1'b0, 8'($urandom)});
    byte_plan[byte_plan.size() - 1][8] = 1'b1;
    foreach (byte_plan[i]) send_byte(byte_plan[i][7:0], byte_plan[i][8]);
  endtask

  // Reset counts: no channels, so bytes are dropped; then one channel over the
  // default row count
  task automatic test_reset_values();
    send_byte(8'h9F, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h00, 1'b1);
    settle_block();
    write_reg(pted_pkg::CFG_CHANNEL_COUNT, 9'd1);
    play_pattern(END_EXACT);
  endtask

  task automatic test_directed_events();
    reconfigure(2, 1);
    // unpacked event: note byte, then instrument, volume, effect, param
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(pted_pkg::EFF_ENV_POS, 1'b0);
    send_byte(8'h00, 1'b0);
    // packed event with every field and reverse playback; it closes the pattern
    send_byte(8'h9F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(pted_pkg::EFF_EXT_X, 1'b0);
    send_byte(8'h9E, 1'b1);
    // empty event marked last while another event is due
    send_byte(8'h80, 1'b1);
    // packed event cut after its note
    send_byte(8'h83, 1'b0);
    send_byte(8'h3C, 1'b1);
    // unpacked event cut after its instrument
    send_byte(8'h45, 1'b0);
    send_byte(8'h12, 1'b1);
    // pattern full: trailing bytes dropped up to the last one
    send_byte(8'hE0, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h9F, 1'b1);
    // extended filter sub-effect, then an unknown effect
    send_byte(8'h98, 1'b0);
    send_byte(pted_pkg::EFF_EXT_E, 1'b0);
    send_byte(8'hF3, 1'b0);
    send_byte(8'h88, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Counts at and beyond their limits, and zero counts
  task automatic test_count_extremes();
    feed_gaps   = 1'b1;
    sink_stalls = 1'b1;
    reconfigure(511, 1);
    write_reg(CFG_SPARE, 9'h1FF);
    play_pattern(END_EXACT);
    reconfigure(1, 511);
    play_pattern(END_OVERRUN);
    reconfigure(CH_LIMIT, ROW_LIMIT);
    play_pattern(END_EARLY);
    play_pattern(END_TRUNCATED);
    reconfigure(0, 5);
    play_pattern(END_NOISE);
    reconfigure(3, 0);
    play_pattern(END_EXACT);
    settle_block();
    write_reg(CFG_SPARE_HI, 9'h000);
  endtask

  // Random counts, endings and idling until the byte budget is spent
  task automatic test_random_patterns();
    int unsigned chans;
    int unsigned rows;
    while (bytes_sent < BYTE_BUDGET) begin
      chans = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 5);
      rows  = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 4);
      reconfigure(chans, rows);
      feed_gaps   = $urandom_range(0, 2) != 0;
      sink_stalls = $urandom_range(0, 2) != 0;
      repeat ($urandom_range(2, 6)) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: play_pattern(END_EXACT);
          9, 10, 11:                 play_pattern(END_OVERRUN);
          12, 13, 14:                play_pattern(END_EARLY);
          15, 16, 17:                play_pattern(END_TRUNCATED);
          default:                   play_pattern(END_NOISE);
        endcase
        // drain everything before the next pattern now and then
        if ($urandom_range(0, 4) == 0) settle_block();
      end
    end
  endtask

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.byte_is_last = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.reg_index   = pted_pkg::CFG_CHANNEL_COUNT;
    cfg_ch.wr_data     = '0;
    mismatches         = 0;
    bytes_sent         = 0;
    idle_cycles        = 0;
    feed_gaps          = 1'b0;
    sink_stalls        = 1'b0;
    shadow_channels    = 9'd0;
    shadow_rows        = 9'd64;
    dec_feat           = '0;
    restart_pattern();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_directed_events();
    test_count_extremes();
    test_random_patterns();

    settle_block();
    if (mismatches == 0) begin
      $display("PASS tracker_pattern_event_decoder");
    end else begin
      $display("FAIL tracker_pattern_event_decoder");
    end
    $finish;
  end

endmodule
